// ----- hdl/bht_pkg.sv -----
// Shared types and constants for the bucketed hash table.
package bht_pkg;

    localparam int BHT_BUCKET_COUNT = 1024;
    localparam int BHT_WAYS         = 4;

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 22;
    localparam int DATE_W  = 8;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int TYPE_W  = 2;
    localparam int PLY_W   = 8;
    localparam int THR_W   = 15;
    localparam int ACT_W   = 2;

    localparam int IN_DATA_W  = 120;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic [THR_W-1:0]           MATE_THR_RESET = 15'd30000;
    localparam logic [TYPE_W-1:0]          BOUND_EXACT    = 2'd0;
    localparam logic signed [SCORE_W:0]    SCORE_MAX      = 17'sd32767;
    localparam logic signed [SCORE_W:0]    SCORE_MIN      = -17'sd32768;

    typedef enum logic [ACT_W-1:0] {
        ACT_STORE  = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_DATE   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [MOVE_W-1:0]  move;
        logic [DATE_W-1:0]  date;
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] depth;
        logic [TYPE_W-1:0]  btype;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int RANK_W  = DEPTH_W + DATE_W;

    typedef struct packed {
        logic              key_eq;
        logic              empty;
        logic              keep_ok;
        logic              better;
        logic [RANK_W-1:0] rank;
    } way_eval_t;

endpackage

// ----- hdl/bht_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bht_bucket_idx.sv -----
// Bucket index unit: key remainder by bucket count, scaled to a base address.
module bht_bucket_idx #(
    parameter int BUCKET_COUNT = bht_pkg::BHT_BUCKET_COUNT,
    parameter int WAYS         = bht_pkg::BHT_WAYS,
    parameter int ADDR_W       = $clog2(BUCKET_COUNT * WAYS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bht_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [ADDR_W-1:0]         base
);
    import bht_pkg::*;

    localparam int   BKT_W    = $clog2(BUCKET_COUNT);
    localparam int   DIG_W    = 4;
    localparam int   DIG_IX_W = $clog2(DIG_W);
    localparam int   STEPS    = KEY_W / DIG_W;
    localparam int   STEP_W   = $clog2(STEPS);
    localparam int   ACC_W    = BKT_W + 3;
    localparam logic IS_POW2  = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

    localparam logic [ACC_W-1:0] BKT_X1 = ACC_W'(BUCKET_COUNT);
    localparam logic [ACC_W-1:0] BKT_X2 = ACC_W'(2 * BUCKET_COUNT);
    localparam logic [ACC_W-1:0] BKT_X3 = ACC_W'(3 * BUCKET_COUNT);
    localparam logic [ACC_W-1:0] BKT_X4 = ACC_W'(4 * BUCKET_COUNT);

    typedef logic [KEY_W-1:0][BKT_W-1:0] pow_tab_t;

    // residue of each key bit weight, two to the power i, by the bucket count
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t tab;
        longint   r;
        r = 1;
        for (int i = 0; i < KEY_W; i++) begin
            tab[i] = BKT_W'(r);
            r = 2 * r;
            if (r >= longint'(BUCKET_COUNT)) begin
                r = r - longint'(BUCKET_COUNT);
            end
        end
        return tab;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [KEY_W-1:0]  key_sh_reg;
    logic [BKT_W-1:0]  rem_reg;
    logic [BKT_W-1:0]  rem_next;
    logic [ADDR_W-1:0] base_reg;
    logic [ACC_W-1:0]  sum;
    logic [ACC_W-1:0]  red;
    logic [BKT_W-1:0]  bucket;
    logic [ADDR_W-1:0] prod;
    logic              finish;

    always_comb begin
        sum = ACC_W'(rem_reg);
        for (int b = 0; b < DIG_W; b++) begin
            if (key_sh_reg[b]) begin
                sum = sum + ACC_W'(POW_TAB[{cnt_reg, DIG_IX_W'(b)}]);
            end
        end
    end

    always_comb begin
        priority if (sum >= BKT_X4) begin
            red = sum - BKT_X4;
        end else if (sum >= BKT_X3) begin
            red = sum - BKT_X3;
        end else if (sum >= BKT_X2) begin
            red = sum - BKT_X2;
        end else if (sum >= BKT_X1) begin
            red = sum - BKT_X1;
        end else begin
            red = sum;
        end
    end

    assign rem_next = red[BKT_W-1:0];
    assign bucket   = IS_POW2 ? key_sh_reg[BKT_W-1:0] : rem_next;
    assign prod     = ADDR_W'(bucket) * ADDR_W'(WAYS);
    assign finish   = busy_reg && (IS_POW2 || (cnt_reg == STEP_W'(STEPS - 1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                rem_reg    <= '0;
                key_sh_reg <= key;
            end else if (finish) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                base_reg <= prod;
            end else if (busy_reg) begin
                cnt_reg    <= cnt_reg + STEP_W'(1);
                rem_reg    <= rem_next;
                key_sh_reg <= {{DIG_W{1'b0}}, key_sh_reg[KEY_W-1:DIG_W]};
            end
        end
    end

    assign done = done_reg;
    assign base = base_reg;

endmodule

// ----- hdl/bht_way_eval.sv -----
// Way evaluation unit: key match, empty test, keep rule and replacement rank.
module bht_way_eval (
    input  bht_pkg::entry_t             entry,
    input  logic [bht_pkg::KEY_W-1:0]   key,
    input  logic [bht_pkg::DEPTH_W-1:0] depth,
    input  logic [bht_pkg::DATE_W-1:0]  date,
    input  logic [bht_pkg::RANK_W:0]    best,
    output bht_pkg::way_eval_t          res
);
    import bht_pkg::*;

    logic [DATE_W-1:0] age;

    assign age         = date - entry.date;
    assign res.key_eq  = (entry.key == key);
    assign res.empty   = (entry.key == '0);
    assign res.keep_ok = (depth >= entry.depth) || (entry.date != date);
    assign res.rank    = {entry.depth, ~age};
    assign res.better  = ({1'b0, res.rank} < best);

endmodule

// ----- hdl/bucketed_hash_table_depth_age_replace.sv -----
// Top level of the bucketed hash table with depth and age replacement.
// Each item runs alone. A store or lookup first indexes the bucket: from the low
// key bits when BUCKET_COUNT is a power of two, else four key bits a cycle through
// the remainder unit. It then reads the ways in turn, one a cycle from the single
// entry-memory read port, writes the chosen way for a store unless a deeper entry
// of the same key and date is kept, and replies. A date advance and a store dropped
// for its bound go straight to the reply. A clear, and the pass after reset during
// which no item is taken, write every entry, one entry a cycle. The next item is
// taken while a result still waits on the output register.
module bucketed_hash_table_depth_age_replace #(
    parameter int BUCKET_COUNT = bht_pkg::BHT_BUCKET_COUNT,
    parameter int WAYS         = bht_pkg::BHT_WAYS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bht_pkg::THR_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key, move, depth, score, bound_type, ply
    input  logic [bht_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [bht_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_move, found_score, found_depth, found_type
    output logic [bht_pkg::OUT_DATA_W-1:0] m_tdata,
    // hit, stored
    output logic [bht_pkg::OUT_USER_W-1:0] m_tuser
);
    import bht_pkg::*;

    localparam int ENTRIES = BUCKET_COUNT * WAYS;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CW      = $clog2(WAYS + 1);
    localparam int IW      = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INDEX = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_REPLY = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;

    state_t              state_reg;
    action_t             act_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [MOVE_W-1:0]   move_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [SCORE_W-1:0]  score_reg;
    logic [TYPE_W-1:0]   btype_reg;
    logic [DATE_W-1:0]   date_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [CW-1:0]       rd_way_reg;
    logic                cmp_vld_reg;
    logic [IW-1:0]       cmp_way_reg;
    logic [IW-1:0]       victim_reg;
    logic [RANK_W:0]     best_reg;
    logic                res_hit_reg;
    logic                res_stored_reg;
    logic [MOVE_W-1:0]   res_move_reg;
    logic [SCORE_W-1:0]  res_score_reg;
    logic [DEPTH_W-1:0]  res_depth_reg;
    logic [TYPE_W-1:0]   res_type_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                clr_reply_reg;
    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    action_t             s_action;
    logic [KEY_W-1:0]    s_key;
    logic [MOVE_W-1:0]   s_move;
    logic [DEPTH_W-1:0]  s_depth;
    logic [SCORE_W-1:0]  s_score;
    logic [TYPE_W-1:0]   s_btype;
    logic [PLY_W-1:0]    s_ply;

    logic signed [SCORE_W:0] sc_ext;
    logic signed [SCORE_W:0] thr_ext;
    logic signed [SCORE_W:0] ply_ext;
    logic signed [SCORE_W:0] sc_sum;
    logic                    mate_hi;
    logic                    mate_lo;
    logic                    drop;
    logic [SCORE_W-1:0]      sc_adj;

    logic                accept;
    logic                reply_fire;
    logic                idx_start;
    logic                idx_done;
    logic [ADDR_W-1:0]   base;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    entry_t              rd_entry;
    logic [ENTRY_W-1:0]  rd_bits;
    entry_t              new_entry;
    way_eval_t           ev;
    logic                last_way;

    assign s_action = action_t'(s_tuser[1:0]);
    assign s_key    = s_tdata[63:0];
    assign s_move   = s_tdata[85:64];
    assign s_depth  = s_tdata[93:86];
    assign s_score  = s_tdata[109:94];
    assign s_btype  = s_tdata[111:110];
    assign s_ply    = s_tdata[119:112];

    assign sc_ext  = {s_score[SCORE_W-1], s_score};
    assign thr_ext = {2'b00, thr_reg};
    assign ply_ext = {{(SCORE_W + 1 - PLY_W){1'b0}}, s_ply};
    assign mate_hi = (sc_ext > thr_ext);
    assign mate_lo = (sc_ext < -thr_ext);
    assign drop    = (mate_hi || mate_lo) && (s_btype != BOUND_EXACT);

    always_comb begin
        priority if (mate_hi) begin
            sc_sum = sc_ext + ply_ext;
        end else if (mate_lo) begin
            sc_sum = sc_ext - ply_ext;
        end else begin
            sc_sum = sc_ext;
        end
    end

    always_comb begin
        priority if (sc_sum > SCORE_MAX) begin
            sc_adj = SCORE_MAX[SCORE_W-1:0];
        end else if (sc_sum < SCORE_MIN) begin
            sc_adj = SCORE_MIN[SCORE_W-1:0];
        end else begin
            sc_adj = sc_sum[SCORE_W-1:0];
        end
    end

    assign accept     = s_tvalid && (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE);
    assign reply_fire = (state_reg == ST_REPLY) && (!m_tvalid_reg || m_tready);
    assign idx_start = accept && ((s_action == ACT_LOOKUP) || ((s_action == ACT_STORE) && !drop));

    bht_bucket_idx #(
        .BUCKET_COUNT(BUCKET_COUNT),
        .WAYS        (WAYS),
        .ADDR_W      (ADDR_W)
    ) u_idx (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (idx_start),
        .key    (s_key),
        .done   (idx_done),
        .base   (base)
    );

    assign new_entry.key   = key_reg;
    assign new_entry.move  = move_reg;
    assign new_entry.date  = date_reg;
    assign new_entry.score = score_reg;
    assign new_entry.depth = depth_reg;
    assign new_entry.btype = btype_reg;

    assign ram_re    = (state_reg == ST_SCAN) && (rd_way_reg < CW'(WAYS));
    assign ram_raddr = base + ADDR_W'(rd_way_reg);
    assign ram_we    = (state_reg == ST_WRITE) || (state_reg == ST_CLEAR);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : base + ADDR_W'(victim_reg);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_entry;

    bht_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES),
        .AW   (ADDR_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    bht_way_eval u_eval (
        .entry(rd_entry),
        .key  (key_reg),
        .depth(depth_reg),
        .date (date_reg),
        .best (best_reg),
        .res  (ev)
    );

    assign last_way = (cmp_way_reg == IW'(WAYS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            date_reg      <= '0;
            thr_reg       <= MATE_THR_RESET;
            m_tvalid_reg  <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            rd_way_reg    <= '0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (reply_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        act_reg        <= s_action;
                        key_reg        <= s_key;
                        move_reg       <= s_move;
                        depth_reg      <= s_depth;
                        score_reg      <= sc_adj;
                        btype_reg      <= s_btype;
                        res_hit_reg    <= 1'b0;
                        res_stored_reg <= 1'b0;
                        res_move_reg   <= '0;
                        res_score_reg  <= '0;
                        res_depth_reg  <= '0;
                        res_type_reg   <= '0;
                        unique case (s_action)
                            ACT_STORE:  state_reg <= drop ? ST_REPLY : ST_INDEX;
                            ACT_LOOKUP: state_reg <= ST_INDEX;
                            ACT_DATE: begin
                                date_reg  <= date_reg + DATE_W'(1);
                                state_reg <= ST_REPLY;
                            end
                            ACT_CLEAR: begin
                                clr_cnt_reg   <= '0;
                                clr_reply_reg <= 1'b1;
                                state_reg     <= ST_CLEAR;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_INDEX: begin
                    if (idx_done) begin
                        rd_way_reg  <= '0;
                        cmp_vld_reg <= 1'b0;
                        best_reg    <= '1;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (ram_re) begin
                        rd_way_reg <= rd_way_reg + CW'(1);
                    end
                    cmp_vld_reg <= ram_re;
                    cmp_way_reg <= rd_way_reg[IW-1:0];
                    if (cmp_vld_reg) begin
                        if (act_reg == ACT_LOOKUP) begin
                            if (ev.key_eq) begin
                                res_hit_reg   <= 1'b1;
                                res_move_reg  <= rd_entry.move;
                                res_score_reg <= rd_entry.score;
                                res_depth_reg <= rd_entry.depth;
                                res_type_reg  <= rd_entry.btype;
                                state_reg     <= ST_REPLY;
                            end else if (last_way) begin
                                state_reg <= ST_REPLY;
                            end
                        end else begin
                            priority if (ev.key_eq) begin
                                victim_reg <= cmp_way_reg;
                                state_reg  <= ev.keep_ok ? ST_WRITE : ST_REPLY;
                            end else if (ev.empty) begin
                                victim_reg <= cmp_way_reg;
                                state_reg  <= ST_WRITE;
                            end else begin
                                if (ev.better) begin
                                    best_reg   <= {1'b0, ev.rank};
                                    victim_reg <= cmp_way_reg;
                                end
                                if (last_way) begin
                                    state_reg <= ST_WRITE;
                                end
                            end
                        end
                    end
                end
                ST_WRITE: begin
                    res_stored_reg <= 1'b1;
                    state_reg      <= ST_REPLY;
                end
                ST_REPLY: begin
                    if (reply_fire) begin
                        m_tdata_reg  <= {res_type_reg, res_depth_reg, res_score_reg,
                                         res_move_reg};
                        m_tuser_reg  <= {res_stored_reg, res_hit_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(ENTRIES - 1)) begin
                        clr_reply_reg <= 1'b0;
                        state_reg     <= clr_reply_reg ? ST_REPLY : ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_write_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> (act_reg == ACT_STORE))
        else $error("entry write outside a store");

    a_date_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_action == ACT_DATE))
            |=> (date_reg == $past(date_reg) + DATE_W'(1)))
        else $error("date did not advance");

    a_hit_store_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit and stored both set");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("found fields set without a hit");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_way_reg <= CW'(WAYS)))
        else $error("way counter past bucket");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the bucketed hash table: directed table, random phases, live predictor.
module testbench;
    import bht_pkg::*;

    localparam logic [TYPE_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [TYPE_W-1:0] BOUND_UPPER = 2'd2;
    localparam logic [TYPE_W-1:0] BOUND_ODD   = 2'd3;

    localparam int SLOTS       = BHT_BUCKET_COUNT * BHT_WAYS;
    localparam int POOL_SIZE   = 36;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 16;
    localparam int MAX_REPORTS = 10;

    localparam logic [KEY_W-1:0] KEY_A    = 64'hFEDC_BA98_7654_3A5A;
    localparam logic [KEY_W-1:0] KEY_B    = 64'h0123_4567_89AB_C25A;
    localparam logic [KEY_W-1:0] KEY_C    = 64'h8000_0000_0000_025A;
    localparam logic [KEY_W-1:0] KEY_D    = 64'h7FFF_FFFF_FFFF_FE5A;
    localparam logic [KEY_W-1:0] KEY_E    = 64'h5555_AAAA_5555_A65A;
    localparam logic [KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        FROM_MODEL,
        ZERO_RESULT,
        EMPTY_HIT
    } verdict_src_t;

    typedef struct packed {
        action_t            act;
        logic [KEY_W-1:0]   key;
        logic [MOVE_W-1:0]  move;
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [TYPE_W-1:0]  btype;
        logic [PLY_W-1:0]   ply;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic               stored;
        logic [MOVE_W-1:0]  move;
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] depth;
        logic [TYPE_W-1:0]  btype;
    } reply_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [MOVE_W-1:0]  move;
        logic [DATE_W-1:0]  date;
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] depth;
        logic [TYPE_W-1:0]  btype;
    } slot_t;

    typedef struct packed {
        req_t         rq;
        verdict_src_t src;
    } row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [THR_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    slot_t             tt_slots [SLOTS];
    logic [DATE_W-1:0] tt_date = '0;
    logic [THR_W-1:0]  tt_thr  = MATE_THR_RESET;
    reply_t            pending [$];
    row_t              dir_rows [$];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    reply_t got;
    reply_t want;
    bit     no_gaps     = 1'b0;
    int     n_acts [4]  = '{0, 0, 0, 0};
    int     n_hits      = 0;
    int     n_written   = 0;
    int     n_fail      = 0;
    int     dead_cycles = 0;
    int     thr_mid     = 0;

    bucketed_hash_table_depth_age_replace i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void tt_wipe();
        for (int i = 0; i < SLOTS; i++) tt_slots[i] = '0;
    endfunction

    function automatic reply_t tt_apply(req_t rq);
        reply_t            r;
        int                base;
        int                sc;
        int                thr;
        int                victim;
        int                rank;
        int                best;
        logic [DATE_W-1:0] age;
        r    = '0;
        base = int'(rq.key % 64'(BHT_BUCKET_COUNT)) * BHT_WAYS;
        case (rq.act)
            ACT_DATE: tt_date = tt_date + 1'b1;
            ACT_CLEAR: tt_wipe();
            ACT_LOOKUP: begin
                for (int k = 0; k < BHT_WAYS; k++) begin
                    if (tt_slots[base + k].key == rq.key) begin
                        r.hit   = 1'b1;
                        r.move  = tt_slots[base + k].move;
                        r.score = tt_slots[base + k].score;
                        r.depth = tt_slots[base + k].depth;
                        r.btype = tt_slots[base + k].btype;
                        return r;
                    end
                end
            end
            ACT_STORE: begin
                sc  = int'($signed(rq.score));
                thr = int'(tt_thr);
                if (sc > thr || sc < -thr) begin
                    if (rq.btype != BOUND_EXACT) return r;
                    sc = (sc > 0) ? sc + int'(rq.ply) : sc - int'(rq.ply);
                end
                if (sc > int'(SCORE_MAX)) sc = int'(SCORE_MAX);
                if (sc < int'(SCORE_MIN)) sc = int'(SCORE_MIN);
                victim = 0;
                best   = 1 << 30;
                for (int k = 0; k < BHT_WAYS; k++) begin
                    if (tt_slots[base + k].key == rq.key) begin
                        if (rq.depth < tt_slots[base + k].depth &&
                            tt_slots[base + k].date == tt_date) return r;
                        victim = k;
                        break;
                    end
                    if (tt_slots[base + k].key == '0) begin
                        victim = k;
                        break;
                    end
                    age  = tt_date - tt_slots[base + k].date;
                    rank = 255 - int'(age) + int'(tt_slots[base + k].depth) * 256;
                    if (rank < best) begin
                        best   = rank;
                        victim = k;
                    end
                end
                tt_slots[base + victim].key   = rq.key;
                tt_slots[base + victim].move  = rq.move;
                tt_slots[base + victim].date  = tt_date;
                tt_slots[base + victim].score = sc[15:0];
                tt_slots[base + victim].depth = rq.depth;
                tt_slots[base + victim].btype = rq.btype;
                r.stored = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(action_t a, logic [KEY_W-1:0] k, logic [MOVE_W-1:0] mv,
                                    logic [DEPTH_W-1:0] dp, int sc, logic [TYPE_W-1:0] bt,
                                    logic [PLY_W-1:0] pl, verdict_src_t src);
        row_t r;
        r.rq.act   = a;
        r.rq.key   = k;
        r.rq.move  = mv;
        r.rq.depth = dp;
        r.rq.score = sc[15:0];
        r.rq.btype = bt;
        r.rq.ply   = pl;
        r.src      = src;
        dir_rows.push_back(r);
    endfunction

    task automatic drive_item(req_t rq, verdict_src_t src);
        reply_t w;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.ply, rq.btype, rq.score, rq.depth, rq.move, rq.key};
        s_tuser  <= rq.act;
        do @(posedge aclk); while (!(s_tready && aresetn));
        w = tt_apply(rq);
        if (src == ZERO_RESULT) begin
            w = '0;
        end else if (src == EMPTY_HIT) begin
            w     = '0;
            w.hit = 1'b1;
        end
        pending.push_back(w);
        n_acts[rq.act]++;
    endtask

    task automatic run_random(int n, bit date_heavy);
        req_t rq;
        int   pick;
        int   sc;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 999);
            if (date_heavy) begin
                if (pick < 800) rq.act = ACT_DATE;
                else if (pick < 900) rq.act = ACT_STORE;
                else if (pick < 998) rq.act = ACT_LOOKUP;
                else rq.act = ACT_CLEAR;
            end else begin
                if (pick < 500) rq.act = ACT_STORE;
                else if (pick < 850) rq.act = ACT_LOOKUP;
                else if (pick < 995) rq.act = ACT_DATE;
                else rq.act = ACT_CLEAR;
            end
            case ($urandom_range(0, 19))
                0: rq.key = '0;
                1, 2: rq.key = {$urandom(), $urandom()};
                default: rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            endcase
            case ($urandom_range(0, 5))
                0: sc = int'($signed(16'($urandom())));
                1: sc = int'(tt_thr) + int'($urandom_range(0, 2)) - 1;
                2: sc = -int'(tt_thr) - int'($urandom_range(0, 2)) + 1;
                3: sc = 32767;
                4: sc = -32768;
                default: sc = int'($urandom_range(0, 100)) - 50;
            endcase
            if (sc > 32767) sc = 32767;
            if (sc < -32768) sc = -32768;
            rq.score = sc[15:0];
            rq.move  = MOVE_W'($urandom());
            rq.depth = $urandom_range(0, 1) ? DEPTH_W'($urandom_range(0, 255))
                                            : DEPTH_W'($urandom_range(0, 7));
            rq.btype = $urandom_range(0, 1) ? BOUND_EXACT : TYPE_W'($urandom_range(1, 3));
            rq.ply   = PLY_W'($urandom());
            drive_item(rq, FROM_MODEL);
        end
    endtask

    task automatic retune(logic [THR_W-1:0] thr);
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tt_thr     = thr;
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (!no_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            {got.btype, got.depth, got.score, got.move} = m_tdata;
            {got.stored, got.hit} = m_tuser;
            n_hits    += got.hit;
            n_written += got.stored;
            if (pending.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("unexpected result: hit=%0b stored=%0b, no item outstanding",
                             got.hit, got.stored);
            end else begin
                want = pending.pop_front();
                if (got.hit !== want.hit || got.stored !== want.stored ||
                    got.move !== want.move || got.score !== want.score ||
                    got.depth !== want.depth || got.btype !== want.btype) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display("mismatch: want hit=%0b stored=%0b move=%h score=%0d depth=%0d type=%0d",
                                 want.hit, want.stored, want.move, $signed(want.score),
                                 want.depth, want.btype);
                        $display("          got  hit=%0b stored=%0b move=%h score=%0d depth=%0d type=%0d",
                                 got.hit, got.stored, got.move, $signed(got.score),
                                 got.depth, got.btype);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) dead_cycles <= 0;
        else dead_cycles <= dead_cycles + 1;
        if (dead_cycles >= STALL_LIMIT) begin
            $display("FAIL bucketed_hash_table_depth_age_replace");
            $finish;
        end
    end

    initial begin
        tt_wipe();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom(), $urandom()};
            if (i >= 6) key_pool[i][9:0] = key_pool[i % 6][9:0];
        end

        add_row(ACT_LOOKUP, KEY_A, '0, '0, 0, BOUND_EXACT, '0, ZERO_RESULT);
        add_row(ACT_LOOKUP, '0, '0, '0, 0, BOUND_EXACT, '0, EMPTY_HIT);
        add_row(ACT_STORE, KEY_A, 22'h3FFFFF, 8'd255, 32767, BOUND_EXACT, 8'd255, FROM_MODEL);
        add_row(ACT_LOOKUP, KEY_A, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_STORE, KEY_B, '0, '0, -32768, BOUND_EXACT, 8'd255, FROM_MODEL);
        add_row(ACT_STORE, KEY_C, 22'h155555, 8'd7, 30001, BOUND_LOWER, 8'd3, ZERO_RESULT);
        add_row(ACT_STORE, KEY_C, 22'h2AAAAA, 8'd7, -30001, BOUND_UPPER, 8'd3, ZERO_RESULT);
        add_row(ACT_STORE, KEY_C, 22'h2AAAAA, 8'd7, 30000, BOUND_ODD, 8'd3, FROM_MODEL);
        add_row(ACT_STORE, KEY_A, 22'h000123, 8'd10, 5, BOUND_EXACT, 8'd0, FROM_MODEL);
        add_row(ACT_DATE, '0, '0, '0, 0, BOUND_EXACT, '0, ZERO_RESULT);
        add_row(ACT_STORE, KEY_A, 22'h000123, 8'd10, -5, BOUND_UPPER, 8'd0, FROM_MODEL);
        add_row(ACT_STORE, KEY_D, 22'h0ABCDE, 8'd3, 1234, BOUND_LOWER, 8'd9, FROM_MODEL);
        add_row(ACT_STORE, KEY_E, 22'h3C3C3C, 8'd1, -1234, BOUND_EXACT, 8'd9, FROM_MODEL);
        add_row(ACT_LOOKUP, KEY_B, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_LOOKUP, KEY_C, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_LOOKUP, KEY_E, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_LOOKUP, KEY_D, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_STORE, KEY_ONES, 22'h3FFFFF, 8'd255, -1, BOUND_ODD, 8'd255, FROM_MODEL);
        add_row(ACT_LOOKUP, KEY_ONES, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_STORE, '0, 22'h012345, 8'd9, 100, BOUND_EXACT, 8'd1, FROM_MODEL);
        add_row(ACT_LOOKUP, '0, '0, '0, 0, BOUND_EXACT, '0, FROM_MODEL);
        add_row(ACT_CLEAR, '0, '0, '0, 0, BOUND_EXACT, '0, ZERO_RESULT);
        add_row(ACT_LOOKUP, KEY_A, '0, '0, 0, BOUND_EXACT, '0, ZERO_RESULT);
        add_row(ACT_LOOKUP, KEY_ONES, '0, '0, 0, BOUND_EXACT, '0, ZERO_RESULT);
        add_row(ACT_STORE, KEY_C, 22'h000001, 8'd0, -32767, BOUND_EXACT, 8'd1, FROM_MODEL);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) drive_item(dir_rows[i].rq, dir_rows[i].src);
        run_random(150, 1'b0);
        retune(15'd0);
        run_random(100, 1'b0);
        retune(15'h7FFF);
        run_random(100, 1'b0);
        thr_mid = $urandom_range(0, 32767);
        retune(THR_W'(thr_mid));
        run_random(150, 1'b1);
        retune(15'd1000);
        no_gaps = 1'b1;
        run_random(130, 1'b1);

        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d stores (%0d written), %0d lookups (%0d hits), %0d date steps, %0d clears",
                 n_acts[ACT_STORE], n_written, n_acts[ACT_LOOKUP], n_hits,
                 n_acts[ACT_DATE], n_acts[ACT_CLEAR]);
        $display("mate thresholds 30000, 0, 32767, %0d and 1000; %0d mismatches", thr_mid, n_fail);
        if (n_fail == 0) begin
            $display("PASS bucketed_hash_table_depth_age_replace");
        end else begin
            $display("FAIL bucketed_hash_table_depth_age_replace");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bht_pkg.sv
hdl/bht_ram.sv
hdl/bht_bucket_idx.sv
hdl/bht_way_eval.sv
hdl/bucketed_hash_table_depth_age_replace.sv
tb/testbench.sv
